### hw/rtl/cba_pkg.sv
`timescale 1ns / 1ps

package cba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 1024;

   localparam int BLK_W    = 10;
   localparam int CNT_W    = 11;
   localparam int FILE_W   = 10;
   localparam int HELD_W   = 11;
   localparam int STATUS_W = 2;
   localparam int DISK_W   = 11;
   localparam int KIND_W   = 2;

   // used map is held as words of WORD_BITS blocks
   localparam int WORD_BITS = 32;
   localparam int SEL_W     = $clog2(WORD_BITS);
   localparam int WIDX_W    = BLK_W - SEL_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QAW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DISK_W-1:0] DISK_RESET = DISK_W'(1024);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd2;

   localparam logic [KIND_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] CMD_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] CMD_READ   = 2'd2;

   typedef logic [DISK_W-1:0] disk_type;

   typedef struct packed {
      logic              op;
      logic [BLK_W-1:0]  first_block;
      logic [CNT_W-1:0]  block_count;
      logic [FILE_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FILE_W-1:0]   file_number;
      logic [BLK_W-1:0]    range_start;
      logic [BLK_W-1:0]    range_end;
      logic [HELD_W-1:0]   files_held;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BLK_W-1:0]  first_block;
      logic [BLK_W-1:0]  last_block;
      logic [FILE_W-1:0] entry_index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // blocks of word w that fall inside [first, last]
   function automatic logic [WORD_BITS-1:0] word_mask(
      input logic [WIDX_W-1:0] w,
      input logic [BLK_W-1:0]  first,
      input logic [BLK_W-1:0]  last
   );
      logic [WORD_BITS-1:0] lo_m;
      logic [WORD_BITS-1:0] hi_m;
      lo_m = {WORD_BITS{1'b1}};
      hi_m = {WORD_BITS{1'b1}};
      if (w == first[BLK_W-1:SEL_W]) begin
         lo_m = {WORD_BITS{1'b1}} << first[SEL_W-1:0];
      end
      if (w == last[BLK_W-1:SEL_W]) begin
         hi_m = {WORD_BITS{1'b1}} >> (~last[SEL_W-1:0]);
      end
      return lo_m & hi_m;
   endfunction

endpackage

### hw/rtl/cba_chan_if.sv
`timescale 1ns / 1ps

interface cba_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/cba_front.sv
`timescale 1ns / 1ps

module cba_front import cba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cba_chan_if.sink    req_ch,
   cba_chan_if.sink    csr_ch,
   input  logic        q_full,
   output logic        push,
   output cmd_type     push_cmd
);

   localparam int STOP_W = CNT_W + 1;

   logic [DISK_W-1:0] disk_ff;
   logic [DISK_W-1:0] disk_in;
   logic [DISK_W-1:0] limit;
   logic [STOP_W-1:0] stop;
   logic              range_ok;
   req_type           req;

   assign csr_ch.ready = 1'b1;
   assign req          = req_ch.payload;

   always_comb begin
      disk_in = disk_ff;
      if (csr_ch.valid) begin
         disk_in = csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff <= DISK_RESET;
      end else begin
         disk_ff <= disk_in;
      end
   end

   always_comb begin
      if (32'(disk_ff) > MAX_BLOCKS) begin
         limit = DISK_W'(MAX_BLOCKS);
      end else begin
         limit = disk_ff;
      end
      stop     = STOP_W'(req.first_block) + STOP_W'(req.block_count);
      range_ok = (req.block_count != '0) && (stop <= STOP_W'(limit));
   end

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      push_cmd.first_block = req.first_block;
      push_cmd.last_block  = BLK_W'(stop - STOP_W'(1));
      push_cmd.entry_index = req.entry_index;
      if (req.op == OP_READ) begin
         push_cmd.kind = CMD_READ;
      end else if (range_ok) begin
         push_cmd.kind = CMD_ALLOC;
      end else begin
         push_cmd.kind = CMD_REJECT;
      end
   end

endmodule

### hw/rtl/cba_queue.sv
`timescale 1ns / 1ps

module cba_queue import cba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  logic      pop,
   output qhead_type head
);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW-1:0]   rd_ptr_in;
   logic [QCW-1:0]   count_ff;
   logic [QCW-1:0]   count_in;

   assign full       = (count_ff == QCW'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/cba_back.sv
`timescale 1ns / 1ps

module cba_back import cba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  qhead_type  head,
   output logic       pop,
   cba_chan_if.source rsp_ch
);

   localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int DAW   = $clog2(MAX_BLOCKS);
   localparam int FTW   = $clog2(MAX_BLOCKS + 1);
   localparam int DIR_W = 2 * BLK_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_DIRRD = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [WIDX_W-1:0]    issue_w_ff, issue_w_in;
   logic                 issue_on_ff, issue_on_in;
   logic                 pend_ff, pend_in;
   logic [WIDX_W-1:0]    pend_w_ff, pend_w_in;
   logic [WAW-1:0]       clr_w_ff, clr_w_in;
   logic [FTW-1:0]       file_total_ff, file_total_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0] used_mem [WORDS];
   logic [WORD_BITS-1:0] used_q_ff;
   logic                 used_re, used_we;
   logic [WAW-1:0]       used_raddr, used_waddr;
   logic [WORD_BITS-1:0] used_wdata;

   logic [DIR_W-1:0]     dir_mem [MAX_BLOCKS];
   logic [DIR_W-1:0]     dir_q_ff;
   logic                 dir_re, dir_we;
   logic [DAW-1:0]       dir_raddr, dir_waddr;
   logic [DIR_W-1:0]     dir_wdata;

   logic [WORD_BITS-1:0] mask;
   logic [WIDX_W-1:0]    hi_w;
   logic                 hit;

   assign mask = word_mask(pend_w_ff, cmd_ff.first_block, cmd_ff.last_block);
   assign hit  = |(used_q_ff & mask);
   assign hi_w = cmd_ff.last_block[BLK_W-1:SEL_W];

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      issue_w_in    = issue_w_ff;
      issue_on_in   = issue_on_ff;
      pend_in       = pend_ff;
      pend_w_in     = pend_w_ff;
      clr_w_in      = clr_w_ff;
      file_total_in = file_total_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      used_re       = 1'b0;
      used_raddr    = WAW'(issue_w_ff);
      used_we       = 1'b0;
      used_waddr    = WAW'(pend_w_ff);
      used_wdata    = used_q_ff | mask;
      dir_re        = 1'b0;
      dir_raddr     = DAW'(head.cmd.entry_index);
      dir_we        = 1'b0;
      dir_waddr     = DAW'(file_total_ff);
      dir_wdata     = {cmd_ff.first_block, cmd_ff.last_block};

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // one word read per cycle during the walks; the read word is registered in used_q_ff
      if (state_ff == S_CHECK || state_ff == S_FILL) begin
         pend_in = issue_on_ff;
         if (issue_on_ff) begin
            used_re   = 1'b1;
            pend_w_in = issue_w_ff;
            if (issue_w_ff == hi_w) begin
               issue_on_in = 1'b0;
            end else begin
               issue_w_in = issue_w_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         S_CLEAR: begin
            used_we    = 1'b1;
            used_waddr = clr_w_ff;
            used_wdata = '0;
            if (clr_w_ff == WAW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_w_in = clr_w_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cmd_in   = head.cmd;
               res_in   = '0;
               res_in.status = ST_ALLOC_FAIL;
               state_in = S_EMIT;
               case (head.cmd.kind)
                  CMD_ALLOC: begin
                     if (32'(file_total_ff) < MAX_BLOCKS) begin
                        issue_w_in  = head.cmd.first_block[BLK_W-1:SEL_W];
                        issue_on_in = 1'b1;
                        pend_in     = 1'b0;
                        state_in    = S_CHECK;
                     end
                  end
                  CMD_READ: begin
                     if (32'(head.cmd.entry_index) < 32'(file_total_ff)) begin
                        dir_re   = 1'b1;
                        state_in = S_DIRRD;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     res_in.status = ST_ALLOC_FAIL;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (pend_ff) begin
               if (hit) begin
                  res_in        = '0;
                  res_in.status = ST_ALLOC_FAIL;
                  issue_on_in   = 1'b0;
                  pend_in       = 1'b0;
                  state_in      = S_EMIT;
               end else if (pend_w_ff == hi_w) begin
                  issue_w_in  = cmd_ff.first_block[BLK_W-1:SEL_W];
                  issue_on_in = 1'b1;
                  pend_in     = 1'b0;
                  state_in    = S_FILL;
               end
            end
         end
         S_FILL: begin
            if (pend_ff) begin
               used_we = 1'b1;
               if (pend_w_ff == hi_w) begin
                  dir_we             = 1'b1;
                  file_total_in      = file_total_ff + 1'b1;
                  res_in.status      = ST_OK;
                  res_in.file_number = FILE_W'(file_total_ff);
                  res_in.range_start = cmd_ff.first_block;
                  res_in.range_end   = cmd_ff.last_block;
                  res_in.files_held  = '0;
                  pend_in            = 1'b0;
                  state_in           = S_EMIT;
               end
            end
         end
         S_DIRRD: begin
            res_in.status      = ST_OK;
            res_in.file_number = cmd_ff.entry_index;
            res_in.range_start = dir_q_ff[DIR_W-1:BLK_W];
            res_in.range_end   = dir_q_ff[BLK_W-1:0];
            res_in.files_held  = '0;
            state_in           = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = res_ff;
               rsp_data_in.files_held = HELD_W'(file_total_ff);
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         issue_on_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         clr_w_ff      <= '0;
         file_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_on_ff   <= issue_on_in;
         pend_ff       <= pend_in;
         clr_w_ff      <= clr_w_in;
         file_total_ff <= file_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      issue_w_ff  <= issue_w_in;
      pend_w_ff   <= pend_w_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (used_re) begin
         used_q_ff <= used_mem[used_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (dir_re) begin
         dir_q_ff <= dir_mem[dir_raddr];
      end
   end

endmodule

### hw/rtl/contiguous_block_allocator.sv
`timescale 1ns / 1ps
// Contiguous block allocator with a file directory.
// req_ch takes one word per operation: allocate (start block, count) or read
// a directory entry by file number. rsp_ch returns one word per request, in
// order. csr_ch writes the disk size; it is always ready, and the user must
// write it only while no request is outstanding; the block does not enforce it.
// A short command queue sits between the request decoder and the executor,
// and the response sits in an output register, so requests are still taken
// while a response waits on a stalled receiver; once the queue is full,
// req_ch.ready drops and nothing is lost.
// The used map is read and written one 32-block word per cycle. An allocate
// walks the words it spans twice, a check walk and then a fill walk; the check
// walk stops at the first word with a used block in range. A rejected allocate
// has no walks, and a directory read reads one directory entry instead.
// After reset the used map is swept clear, one word per cycle, MAX_BLOCKS/32
// words (32 by default); requests wait in the queue meanwhile. The file
// count returns to zero and the disk size to 1024.
module contiguous_block_allocator import cba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   cba_chan_if.sink   req_ch,
   cba_chan_if.source rsp_ch,
   cba_chan_if.sink   csr_ch
);

   logic      push;
   cmd_type   push_cmd;
   logic      q_full;
   logic      pop;
   qhead_type head;

   cba_front #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .csr_ch   (csr_ch),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   cba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   cba_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
